### rtl/wsfe_pkg.sv
package wsfe_pkg;

    // Command codes carried on the input channel
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // Field widths
    localparam int LEN_W  = 63;
    localparam int OP_W   = 4;
    localparam int KEY_W  = 32;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 4;

    // Header encoding constants
    localparam logic [BYTE_W-1:0] FIN_BIT      = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_BIT     = 8'h80;
    localparam logic [LEN_W-1:0]  LEN_7BIT_MAX = 63'd125;
    localparam logic [LEN_W-1:0]  LEN_16BIT_MAX = 63'd65535;
    localparam logic [6:0]        LEN_CODE_16  = 7'd126;
    localparam logic [6:0]        LEN_CODE_64  = 7'd127;

    // First mask byte position per length form, and the number of mask key bytes
    localparam logic [IDX_W-1:0] KEY_BASE_7  = 4'd2;
    localparam logic [IDX_W-1:0] KEY_BASE_16 = 4'd4;
    localparam logic [IDX_W-1:0] KEY_BASE_64 = 4'd10;
    localparam logic [IDX_W-1:0] KEY_BYTES   = 4'd4;

    typedef enum logic [1:0] {
        LEN_FORM_7,
        LEN_FORM_16,
        LEN_FORM_64
    } len_form_t;

    // Frame state updates, issued when an item's last byte is registered
    typedef struct packed {
        logic start_commit;
        logic payload_commit;
    } commit_t;

endpackage

### rtl/wsfe_header.sv
module wsfe_header (
    input  logic [wsfe_pkg::LEN_W-1:0]  frame_length,
    input  logic [wsfe_pkg::OP_W-1:0]   frame_opcode,
    input  logic [wsfe_pkg::KEY_W-1:0]  mask_key,
    input  logic [wsfe_pkg::IDX_W-1:0]  idx,
    output logic [wsfe_pkg::BYTE_W-1:0] hdr_byte,
    output logic                        hdr_last,
    output logic                        hdr_empty
);
    import wsfe_pkg::*;

    len_form_t        form;
    logic [IDX_W-1:0] key_base;
    logic [IDX_W-1:0] key_off;
    logic [IDX_W-1:0] len_pos;
    logic [63:0]      len_ext;
    logic [6:0]       len_code;

    // Length form from the payload size
    always_comb begin
        if (frame_length <= LEN_7BIT_MAX) begin
            form = LEN_FORM_7;
        end else if (frame_length <= LEN_16BIT_MAX) begin
            form = LEN_FORM_16;
        end else begin
            form = LEN_FORM_64;
        end
    end

    // Byte positions for the chosen form
    always_comb begin
        unique case (form)
            LEN_FORM_7: begin
                key_base = KEY_BASE_7;
                len_code = frame_length[6:0];
            end
            LEN_FORM_16: begin
                key_base = KEY_BASE_16;
                len_code = LEN_CODE_16;
            end
            LEN_FORM_64: begin
                key_base = KEY_BASE_64;
                len_code = LEN_CODE_64;
            end
            default: begin
                key_base = KEY_BASE_64;
                len_code = LEN_CODE_64;
            end
        endcase
    end

    assign len_ext = {1'b0, frame_length};
    assign key_off = idx - key_base;
    // extended length is big-endian: position counts down to the low byte
    assign len_pos = key_base - 4'd1 - idx;

    // Header byte select
    always_comb begin
        if (idx == 4'd0) begin
            hdr_byte = FIN_BIT | {4'd0, frame_opcode};
        end else if (idx == 4'd1) begin
            hdr_byte = MASK_BIT | {1'b0, len_code};
        end else if (idx >= key_base) begin
            hdr_byte = mask_key[key_off[1:0]*8 +: 8];
        end else begin
            hdr_byte = len_ext[len_pos[2:0]*8 +: 8];
        end
    end

    assign hdr_last  = (idx == key_base + KEY_BYTES - 4'd1);
    assign hdr_empty = (frame_length == '0);

endmodule

### rtl/wsfe_framer.sv
module wsfe_framer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wsfe_pkg::commit_t           commit,
    input  logic [wsfe_pkg::LEN_W-1:0]  frame_length,
    input  logic [wsfe_pkg::KEY_W-1:0]  mask_key,
    input  logic [wsfe_pkg::BYTE_W-1:0] payload_byte,
    output logic [wsfe_pkg::BYTE_W-1:0] pay_byte,
    output logic                        pay_done,
    output logic                        pay_status
);
    import wsfe_pkg::*;

    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [KEY_W-1:0] held_mask_reg, held_mask_next;
    logic [1:0]       mask_phase_reg, mask_phase_next;
    logic             frame_open_reg, frame_open_next;
    logic [LEN_W-1:0] left_dec;

    assign left_dec = bytes_left_reg - 63'd1;

    // Masked payload byte, or an error result when no frame is open
    always_comb begin
        if (frame_open_reg) begin
            pay_byte   = payload_byte ^ held_mask_reg[mask_phase_reg*8 +: 8];
            pay_done   = (left_dec == '0);
            pay_status = 1'b0;
        end else begin
            pay_byte   = '0;
            pay_done   = 1'b0;
            pay_status = 1'b1;
        end
    end

    // Frame state update
    always_comb begin
        bytes_left_next = bytes_left_reg;
        held_mask_next  = held_mask_reg;
        mask_phase_next = mask_phase_reg;
        frame_open_next = frame_open_reg;
        if (commit.start_commit) begin
            bytes_left_next = frame_length;
            held_mask_next  = mask_key;
            mask_phase_next = 2'd0;
            frame_open_next = (frame_length != '0);
        end else if (commit.payload_commit && frame_open_reg) begin
            bytes_left_next = left_dec;
            mask_phase_next = mask_phase_reg + 2'd1;
            frame_open_next = (left_dec != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            held_mask_reg  <= '0;
            mask_phase_reg <= '0;
            frame_open_reg <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            held_mask_reg  <= held_mask_next;
            mask_phase_reg <= mask_phase_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

### rtl/websocket_frame_encoder.sv
// Channel  | Direction | Handshake         | Payload
// s_       | in        | s_valid / s_ready | cmd, frame_length, frame_opcode, mask_key, payload_byte
// m_       | out       | m_valid / m_ready | out_byte, last_of_run, frame_done, status
//
// A payload request yields one byte; a start request yields 6, 8 or 14 header bytes,
// one per cycle while m_ready does not stall, walked by the byte index counter.
// Requests are held in an input register and results in an output register, so a
// new request is taken in the cycle its predecessor's last byte is registered.
// A stall on m_ready freezes the header walk and, once the input register is full,
// drops s_ready. Reset (aresetn low, synchronous) clears the frame state, no frame open.
module websocket_frame_encoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic [wsfe_pkg::LEN_W-1:0]  s_frame_length,
    input  logic [wsfe_pkg::OP_W-1:0]   s_frame_opcode,
    input  logic [wsfe_pkg::KEY_W-1:0]  s_mask_key,
    input  logic [wsfe_pkg::BYTE_W-1:0] s_payload_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [wsfe_pkg::BYTE_W-1:0] m_out_byte,
    output logic                        m_last_of_run,
    output logic                        m_frame_done,
    output logic                        m_status
);
    import wsfe_pkg::*;

    // Input register
    logic              in_valid_reg, in_valid_next;
    logic              cmd_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [BYTE_W-1:0] pbyte_reg;

    // Header walk
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              last_reg, done_reg, status_reg;

    logic [BYTE_W-1:0] hdr_byte, pay_byte;
    logic              hdr_last, hdr_empty, pay_done, pay_status;
    logic              out_free, fire, item_last, finish;
    commit_t           commit;

    wsfe_header u_header (
        .frame_length (len_reg),
        .frame_opcode (op_reg),
        .mask_key     (key_reg),
        .idx          (idx_reg),
        .hdr_byte     (hdr_byte),
        .hdr_last     (hdr_last),
        .hdr_empty    (hdr_empty)
    );

    wsfe_framer u_framer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .commit       (commit),
        .frame_length (len_reg),
        .mask_key     (key_reg),
        .payload_byte (pbyte_reg),
        .pay_byte     (pay_byte),
        .pay_done     (pay_done),
        .pay_status   (pay_status)
    );

    // Handshake control
    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_free;
    assign item_last = (cmd_reg == CMD_PAYLOAD) ? 1'b1 : hdr_last;
    assign finish    = fire && item_last;
    assign s_ready   = !in_valid_reg || finish;

    assign commit.start_commit   = finish && (cmd_reg == CMD_START);
    assign commit.payload_commit = finish && (cmd_reg == CMD_PAYLOAD);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (finish) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (finish) begin
            idx_next = '0;
        end else if (fire) begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            len_reg   <= s_frame_length;
            op_reg    <= s_frame_opcode;
            key_reg   <= s_mask_key;
            pbyte_reg <= s_payload_byte;
        end
    end

    // Result capture
    always_ff @(posedge aclk) begin
        if (fire) begin
            last_reg <= item_last;
            if (cmd_reg == CMD_PAYLOAD) begin
                out_byte_reg <= pay_byte;
                done_reg     <= pay_done;
                status_reg   <= pay_status;
            end else begin
                out_byte_reg <= hdr_byte;
                done_reg     <= hdr_last && hdr_empty;
                status_reg   <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_last_of_run = last_reg;
    assign m_frame_done  = done_reg;
    assign m_status      = status_reg;

endmodule

### sim/websocket_frame_encoder_test.sv
`timescale 1ns / 100ps

module websocket_frame_encoder_test;

    import wsfe_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 20;

    // One request on the input channel
    typedef struct packed {
        logic              cmd;
        logic [LEN_W-1:0]  frame_length;
        logic [OP_W-1:0]   frame_opcode;
        logic [KEY_W-1:0]  mask_key;
        logic [BYTE_W-1:0] payload_byte;
    } ws_request_t;

    // One byte on the wire, with its flags
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              frame_done;
        logic              status;
    } wire_byte_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_cmd;
    logic [LEN_W-1:0]  s_frame_length;
    logic [OP_W-1:0]   s_frame_opcode;
    logic [KEY_W-1:0]  s_mask_key;
    logic [BYTE_W-1:0] s_payload_byte;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_last_of_run;
    logic              m_frame_done;
    logic              m_status;

    // Encoder state as predicted
    logic [LEN_W-1:0]  bytes_pending;
    logic [KEY_W-1:0]  frame_key;
    logic [1:0]        key_phase;
    logic              frame_active;

    wire_byte_t        expected_wire_q[$];
    int                error_count = 0;
    int                items_sent = 0;
    int                cycle_count = 0;
    int                tx_max_gap = 15;
    int                rx_max_gap = 15;
    int                rx_stall_cycles = 0;

    websocket_frame_encoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_frame_length (s_frame_length),
        .s_frame_opcode (s_frame_opcode),
        .s_mask_key     (s_mask_key),
        .s_payload_byte (s_payload_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run),
        .m_frame_done   (m_frame_done),
        .m_status       (m_status)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Frame encoding: queue the wire bytes one request produces
    function automatic void encode_frame_request(input ws_request_t rq);
        logic [BYTE_W-1:0] hdr[14];
        logic [63:0]       len64;
        logic [BYTE_W-1:0] key_byte;
        logic              done;
        int                n;
        len64 = {1'b0, rq.frame_length};
        if (rq.cmd == CMD_START) begin
            hdr[0] = FIN_BIT | {4'd0, rq.frame_opcode};
            if (rq.frame_length <= LEN_7BIT_MAX) begin
                hdr[1] = MASK_BIT | len64[7:0];
                n = 2;
            end else if (rq.frame_length <= LEN_16BIT_MAX) begin
                hdr[1] = MASK_BIT | {1'b0, LEN_CODE_16};
                hdr[2] = len64[15:8];
                hdr[3] = len64[7:0];
                n = 4;
            end else begin
                hdr[1] = MASK_BIT | {1'b0, LEN_CODE_64};
                n = 2;
                for (int i = 7; i >= 0; i--) begin
                    hdr[n] = len64[8*i +: 8];
                    n++;
                end
            end
            // mask key, low byte first
            for (int i = 0; i < 4; i++) begin
                hdr[n] = rq.mask_key[8*i +: 8];
                n++;
            end
            for (int i = 0; i < n; i++) begin
                done = (i == n - 1) && (rq.frame_length == '0);
                expected_wire_q.push_back({hdr[i], i == n - 1, done, 1'b0});
            end
            bytes_pending = rq.frame_length;
            frame_key     = rq.mask_key;
            key_phase     = 2'd0;
            frame_active  = (rq.frame_length != '0);
        end else if (!frame_active || bytes_pending == '0) begin
            // payload byte outside any frame
            expected_wire_q.push_back({8'h00, 1'b1, 1'b0, 1'b1});
        end else begin
            key_byte      = frame_key[8*key_phase +: 8];
            bytes_pending = bytes_pending - 63'd1;
            key_phase     = key_phase + 2'd1;
            done          = (bytes_pending == '0);
            if (done)
                frame_active = 1'b0;
            expected_wire_q.push_back({rq.payload_byte ^ key_byte, 1'b1, done, 1'b0});
        end
    endfunction

    // Predict on accepted requests, compare accepted results
    always @(posedge aclk) begin
        wire_byte_t wire_due;
        if (aresetn) begin
            if (s_valid && s_ready)
                encode_frame_request({s_cmd, s_frame_length, s_frame_opcode,
                                      s_mask_key, s_payload_byte});
            if (m_valid && m_ready) begin
                if (expected_wire_q.size() == 0) begin
                    $error("unexpected result: out_byte %h", m_out_byte);
                    error_count++;
                end else begin
                    wire_due = expected_wire_q.pop_front();
                    if (m_out_byte !== wire_due.out_byte) begin
                        $error("out_byte: expected %h, got %h", wire_due.out_byte, m_out_byte);
                        error_count++;
                    end
                    if (m_last_of_run !== wire_due.last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               wire_due.last_of_run, m_last_of_run);
                        error_count++;
                    end
                    if (m_frame_done !== wire_due.frame_done) begin
                        $error("frame_done: expected %b, got %b",
                               wire_due.frame_done, m_frame_done);
                        error_count++;
                    end
                    if (m_status !== wire_due.status) begin
                        $error("status: expected %b, got %b", wire_due.status, m_status);
                        error_count++;
                    end
                end
            end
        end
    end

    // Result side: random ready gaps, plus a long hold when requested
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_stall_cycles > 0) begin
                gap = rx_stall_cycles;
                rx_stall_cycles = 0;
            end else begin
                gap = $urandom_range(0, rx_max_gap);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offer one request; called at a falling edge, returns at a falling edge
    task automatic send_request(input logic cmd, input logic [LEN_W-1:0] len,
                                input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [BYTE_W-1:0] pb);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_cmd          <= cmd;
        s_frame_length <= len;
        s_frame_opcode <= op;
        s_mask_key     <= key;
        s_payload_byte <= pb;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Start request; the unused payload byte carries noise
    task automatic send_start(input logic [LEN_W-1:0] len, input logic [OP_W-1:0] op,
                              input logic [KEY_W-1:0] key);
        send_request(CMD_START, len, op, key, BYTE_W'($urandom_range(0, 255)));
    endtask

    // Payload request; the unused header fields carry noise
    task automatic send_payload(input logic [BYTE_W-1:0] pb);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        send_request(CMD_PAYLOAD, noise[LEN_W-1:0], OP_W'($urandom_range(0, 15)),
                     $urandom, pb);
    endtask

    // Random frames, well-formed, abandoned or overrun, and stray bytes
    task automatic send_random_frame();
        int               kind;
        int               n_payload;
        logic [63:0]      r;
        logic [LEN_W-1:0] len;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            send_payload(BYTE_W'($urandom_range(0, 255)));
        end else begin
            if (kind < 65) begin
                len = LEN_W'($urandom_range(0, 9));
            end else if (kind < 75) begin
                len = LEN_W'($urandom_range(120, 131));
            end else if (kind < 85) begin
                len = LEN_W'($urandom_range(65530, 65541));
            end else begin
                r = {$urandom, $urandom};
                len = r[LEN_W-1:0] >> $urandom_range(0, 46);
                if (len <= LEN_16BIT_MAX)
                    len = len + 63'd65536;
            end
            send_start(len, OP_W'($urandom_range(0, 15)), $urandom);
            if (len <= 9) begin
                kind = $urandom_range(0, 99);
                if (kind < 75)
                    n_payload = int'(len);
                else if (kind < 90)
                    n_payload = int'($urandom_range(0, int'(len)));
                else
                    n_payload = int'(len) + int'($urandom_range(1, 3));
            end else begin
                n_payload = $urandom_range(0, 6);
            end
            repeat (n_payload) send_payload(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Payload bytes right after reset find no frame
    task automatic test_stray_payload();
        send_payload(8'h00);
        send_payload(8'hFF);
    endtask

    // Empty frame and a byte after it, an abandoned frame, then a short frame run to completion and one byte past it
    task automatic test_short_frames();
        send_start(63'd0, 4'hF, 32'hFFFF_FFFF);
        send_payload(8'hA5);
        send_start(63'd5, 4'h0, 32'h0000_0000);
        send_start(63'd5, 4'h1, 32'h1234_5678);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'hAA);
        send_payload(8'h55);
        send_payload(8'h3C);
        send_payload(8'h77);
    endtask

    // Each length form at its boundaries; each later start abandons the previous frame
    task automatic test_length_forms();
        send_start(63'd125, 4'h2, 32'hDEAD_BEEF);
        send_payload(8'h11);
        send_start(63'd126, 4'h8, 32'h0F0F_F0F0);
        send_payload(8'h22);
        send_start(63'd65535, 4'h9, 32'hA5A5_5A5A);
        send_start(63'd65536, 4'hA, 32'h8000_0001);
        send_payload(8'h33);
        send_start({LEN_W{1'b1}}, 4'h7, 32'hC3C3_3C3C);
        send_payload(8'h44);
        send_payload(8'h88);
    endtask

    task automatic test_random_traffic(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target)
            send_random_frame();
    endtask

    // No idling on either side
    task automatic test_full_rate(input int n_items);
        int target;
        tx_max_gap = 0;
        rx_max_gap = 0;
        target = items_sent + n_items;
        while (items_sent < target)
            send_random_frame();
        tx_max_gap = 15;
        rx_max_gap = 15;
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure(input int n_items);
        int target;
        tx_max_gap = 0;
        rx_stall_cycles = 400;
        target = items_sent + n_items;
        while (items_sent < target)
            send_random_frame();
        tx_max_gap = 15;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = CMD_START;
        s_frame_length = '0;
        s_frame_opcode = '0;
        s_mask_key     = '0;
        s_payload_byte = '0;
        bytes_pending  = '0;
        frame_key      = '0;
        key_phase      = 2'd0;
        frame_active   = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_stray_payload();
        test_short_frames();
        test_length_forms();
        test_random_traffic(230);
        test_full_rate(40);
        test_backpressure(40);
        test_random_traffic(30);

        s_valid <= 1'b0;
        while (expected_wire_q.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
